// ===== rtl/gcq_pkg.sv =====
// Package for the pin change qualifier.
// Register indexes, mode codes and result packing; no dependencies.
package gcq_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned SECONDS_W   = 13;
  localparam int unsigned THRESH_W    = 12;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [SECONDS_W-1:0] SECONDS_MAX = '1;
  localparam logic [3:0]           FRAC_LAST   = 4'd9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE            = 3'd0,
    REG_INTERVAL        = 3'd1,
    REG_ONLY_VALUE_EN   = 3'd2,
    REG_ONLY_VALUE      = 3'd3,
    REG_KEEP_RUNNING    = 3'd4,
    REG_INVERT_SCRIPT   = 3'd5,
    REG_SCRIPT_EN       = 3'd6,
    REG_SCRIPT_STARTUP  = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_DIRECT   = 2'd0,
    MODE_INTERVAL = 2'd1,
    MODE_WAIT     = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  // Result bit positions in m_tdata
  localparam int unsigned BIT_REPORT_VALID = 0;
  localparam int unsigned BIT_REPORT_LEVEL = 1;
  localparam int unsigned BIT_SECONDS_LO   = 2;
  localparam int unsigned BIT_SECONDS_HI   = 14;
  localparam int unsigned BIT_SCRIPT_TRIG  = 15;
  localparam int unsigned BIT_SCRIPT_LEVEL = 16;
  localparam int unsigned BIT_HALTED       = 17;
  localparam int unsigned BIT_FAST         = 18;

  typedef struct packed {
    logic                 fast_sampling;
    logic                 halted_now;
    logic                 script_level;
    logic                 script_trigger;
    logic [SECONDS_W-1:0] report_seconds;
    logic                 report_level;
    logic                 report_valid;
  } result_t;

endpackage

// ===== rtl/gpio_change_qualifier.sv =====
// Pin change qualifier: one pin sample in, one result out per transaction.
// The result of an accepted sample is registered in the output register.
// Throughput: one sample per cycle; the output register stalls the input only
// while a held result is not taken.
// Reset (rst, synchronous): output register empty, registers and state cleared,
// first-sample flag set.
// Depends on gcq_pkg.
module gpio_change_qualifier #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gcq_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] level, rest zero
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] report_valid, [1] report_level, [14:2] report_seconds, [15] script_trigger,
  // [16] script_level, [17] halted_now, [18] fast_sampling, rest zero
  output logic [gcq_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [gcq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gcq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > gcq_pkg::THRESH_W) ? COUNT_WIDTH : gcq_pkg::THRESH_W;
  localparam int unsigned PAD_W = gcq_pkg::OUT_TDATA_W - $bits(gcq_pkg::result_t);

  // Configuration
  gcq_pkg::mode_t mode;
  logic [7:0]     interval_seconds;
  logic           only_value_enable;
  logic           only_value;
  logic           keep_running;
  logic           invert_script_value;
  logic           script_enable;
  logic           script_at_startup;

  // State
  logic                   first_sample, first_sample_next;
  logic                   last_level, last_level_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic                   fast_rate, fast_rate_next;
  logic                   stopped, stopped_next;
  // tick_count/10 kept alongside the counter
  logic [gcq_pkg::SECONDS_W-1:0] sec_count, sec_count_next;
  logic [3:0]                    sec_frac, sec_frac_next;

  gcq_pkg::result_t res;
  logic             accept;
  logic             level;

  logic [gcq_pkg::THRESH_W-1:0] thresh;
  logic [COUNT_WIDTH-1:0]       tc_inc;
  logic                         can_inc;

  assign level    = s_tdata[0];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign thresh  = {interval_seconds, 3'b000} + {2'b00, interval_seconds, 1'b0};
  assign can_inc = (tick_count != '1);
  assign tc_inc  = can_inc ? tick_count + 1'b1 : tick_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= gcq_pkg::MODE_DIRECT;
      interval_seconds    <= '0;
      only_value_enable   <= 1'b0;
      only_value          <= 1'b0;
      keep_running        <= 1'b0;
      invert_script_value <= 1'b0;
      script_enable       <= 1'b0;
      script_at_startup   <= 1'b0;
    end else if (cfg_we) begin
      unique case (gcq_pkg::reg_index_t'(cfg_index))
        gcq_pkg::REG_MODE:           mode <= gcq_pkg::mode_t'(cfg_data[1:0]);
        gcq_pkg::REG_INTERVAL:       interval_seconds <= cfg_data;
        gcq_pkg::REG_ONLY_VALUE_EN:  only_value_enable <= cfg_data[0];
        gcq_pkg::REG_ONLY_VALUE:     only_value <= cfg_data[0];
        gcq_pkg::REG_KEEP_RUNNING:   keep_running <= cfg_data[0];
        gcq_pkg::REG_INVERT_SCRIPT:  invert_script_value <= cfg_data[0];
        gcq_pkg::REG_SCRIPT_EN:      script_enable <= cfg_data[0];
        gcq_pkg::REG_SCRIPT_STARTUP: script_at_startup <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic ll;
    logic qual;
    logic do_inc;
    logic do_clr;
    logic wait_mode;
    logic v;

    first_sample_next = first_sample;
    last_level_next   = last_level;
    tick_count_next   = tick_count;
    fast_rate_next    = fast_rate;
    stopped_next      = stopped;
    sec_count_next    = sec_count;
    sec_frac_next     = sec_frac;
    res               = '0;
    ll                = first_sample ? level : last_level;
    qual              = 1'b0;
    do_inc            = 1'b0;
    do_clr            = 1'b0;
    wait_mode         = (mode == gcq_pkg::MODE_WAIT);
    v                 = wait_mode ? ~level : level;

    if (stopped) begin
      res.halted_now = 1'b1;
    end else begin
      first_sample_next = 1'b0;
      last_level_next   = ll;
      if (first_sample && script_at_startup) begin
        res.script_trigger = 1'b1;
        res.script_level   = level ^ invert_script_value;
      end

      if (level != ll) begin
        case (mode)
          gcq_pkg::MODE_WAIT: begin
            fast_rate_next = 1'b1;
            do_inc         = 1'b1;
          end
          gcq_pkg::MODE_INTERVAL: begin
            fast_rate_next = 1'b1;
            do_inc         = 1'b1;
            qual = (CMP_W'(tc_inc) > CMP_W'(thresh));
          end
          default: qual = 1'b1;
        endcase
      end else if (tick_count != '0) begin
        if (wait_mode) begin
          qual = 1'b1;
        end else if (mode == gcq_pkg::MODE_INTERVAL) begin
          do_clr         = 1'b1;
          fast_rate_next = 1'b0;
        end
      end

      if (qual) begin
        if (!only_value_enable) begin
          res.report_valid   = 1'b1;
          res.report_level   = v;
          res.report_seconds = wait_mode ? sec_count : '0;
          if (script_enable) begin
            res.script_trigger = 1'b1;
            res.script_level   = v ^ invert_script_value;
          end
          if (!keep_running) begin
            stopped_next = 1'b1;
          end else begin
            do_clr          = 1'b1;
            last_level_next = v;
            fast_rate_next  = 1'b0;
          end
        end else if (level == only_value) begin
          res.report_valid = 1'b1;
          res.report_level = level;
          if (!keep_running) begin
            stopped_next = 1'b1;
          end else begin
            do_clr          = 1'b1;
            last_level_next = level;
            fast_rate_next  = 1'b0;
          end
        end else begin
          last_level_next = level;
        end
        if (wait_mode && !stopped_next) begin
          do_clr         = 1'b1;
          fast_rate_next = 1'b0;
        end
      end

      if (do_clr) begin
        tick_count_next = '0;
        sec_count_next  = '0;
        sec_frac_next   = '0;
      end else if (do_inc && can_inc) begin
        tick_count_next = tc_inc;
        if (sec_frac == gcq_pkg::FRAC_LAST) begin
          sec_frac_next = '0;
          if (sec_count != gcq_pkg::SECONDS_MAX) begin
            sec_count_next = sec_count + 1'b1;
          end
        end else begin
          sec_frac_next = sec_frac + 1'b1;
        end
      end

      res.halted_now    = stopped_next;
      res.fast_sampling = stopped_next ? 1'b0 : fast_rate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample <= 1'b1;
      last_level   <= 1'b0;
      tick_count   <= '0;
      fast_rate    <= 1'b0;
      stopped      <= 1'b0;
      sec_count    <= '0;
      sec_frac     <= '0;
    end else if (accept) begin
      first_sample <= first_sample_next;
      last_level   <= last_level_next;
      tick_count   <= tick_count_next;
      fast_rate    <= fast_rate_next;
      stopped      <= stopped_next;
      sec_count    <= sec_count_next;
      sec_frac     <= sec_frac_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{PAD_W{1'b0}}, res};
    end
  end

endmodule

// ===== rtl/gcq_checker.sv =====
// Port-level checks for the pin change qualifier, bound to the top level.
// Depends on gcq_pkg.
module gcq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [gcq_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic halted_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      halted_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[gcq_pkg::BIT_HALTED]) begin
      halted_seen <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted_seen && m_tvalid |-> m_tdata[gcq_pkg::BIT_HALTED])
    else $error("block resumed after halting");

  a_no_report_no_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[gcq_pkg::BIT_REPORT_VALID] |->
      !m_tdata[gcq_pkg::BIT_REPORT_LEVEL] &&
      m_tdata[gcq_pkg::BIT_SECONDS_HI:gcq_pkg::BIT_SECONDS_LO] == '0)
    else $error("report fields set without a report");

  a_halted_fast_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[gcq_pkg::BIT_HALTED] |-> !m_tdata[gcq_pkg::BIT_FAST])
    else $error("fast sampling flagged while halted");

endmodule

bind gpio_change_qualifier gcq_checker u_gcq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
